### hw/rtl/chm_pkg.sv
// package for the chained hash map: constants, op and status codes, state enum,
// word structs and the controller/datapath command and status structs
// no dependencies
`default_nettype none
package chm_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 256;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] found_value;
    } out_word_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HEAD,
        S_HEAD_WAIT,
        S_NODE,
        S_NODE_WAIT,
        S_CHECK,
        S_PUT_POP,
        S_PUT_WAIT,
        S_PUT_WRITE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic init_step;    // write free stack entry at the init counter
        logic latch_in;     // capture the input word
        logic rd_head;      // read bucket head of the latched key
        logic take_head;    // cursor <= head read data
        logic rd_node;      // read node at the cursor
        logic advance;      // prev <= cursor, cursor <= link, count step
        logic rd_free;      // read free stack at top-1
        logic put_write;    // write node, head, pop the free stack
        logic erase_write;  // unlink cursor node, push it on the free stack
        logic set_found;    // result ok with the node value
        logic set_ok;       // result ok, zero value
        logic set_miss;     // result not found
        logic set_full;     // result pool full
        logic emit;         // strobe the result word
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic cur_ok;       // cursor valid and step bound not reached
        logic key_match;    // node key equals latched key
        logic pool_empty;
        logic [1:0] op;
    } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/chm_ram.sv
// generic single port write, single port registered read ram
// no dependencies
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/chm_ctrl.sv
// controller state machine for the chained hash map
// depends on chm_pkg
`default_nettype none
module chm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire chm_pkg::dp_stat_t stat,
    output chm_pkg::ctl_t          ctl,
    output logic                   busy
);
    chm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            chm_pkg::S_INIT:
            begin
                ctl.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = chm_pkg::S_HEAD;
                end
            end
            chm_pkg::S_HEAD:
            begin
                if (stat.op == chm_pkg::OP_PUT)
                begin
                    if (stat.pool_empty)
                    begin
                        ctl.set_full = 1'b1;
                        state_next   = chm_pkg::S_DONE;
                    end
                    else
                    begin
                        ctl.rd_free = 1'b1;
                        ctl.rd_head = 1'b1;
                        state_next  = chm_pkg::S_PUT_WAIT;
                    end
                end
                else if (stat.op == chm_pkg::OP_GET || stat.op == chm_pkg::OP_ERASE)
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = chm_pkg::S_HEAD_WAIT;
                end
                else
                begin
                    ctl.set_miss = 1'b1;
                    state_next   = chm_pkg::S_DONE;
                end
            end
            chm_pkg::S_HEAD_WAIT:
            begin
                ctl.take_head = 1'b1;
                state_next    = chm_pkg::S_NODE;
            end
            chm_pkg::S_NODE:
            begin
                if (stat.cur_ok)
                begin
                    ctl.rd_node = 1'b1;
                    state_next  = chm_pkg::S_NODE_WAIT;
                end
                else
                begin
                    ctl.set_miss = 1'b1;
                    state_next   = chm_pkg::S_DONE;
                end
            end
            chm_pkg::S_NODE_WAIT:
            begin
                state_next = chm_pkg::S_CHECK;
            end
            chm_pkg::S_CHECK:
            begin
                if (stat.key_match)
                begin
                    if (stat.op == chm_pkg::OP_GET)
                    begin
                        ctl.set_found = 1'b1;
                    end
                    else
                    begin
                        ctl.erase_write = 1'b1;
                        ctl.set_ok      = 1'b1;
                    end
                    state_next = chm_pkg::S_DONE;
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next  = chm_pkg::S_NODE;
                end
            end
            chm_pkg::S_PUT_POP:
            begin
                state_next = chm_pkg::S_PUT_WAIT;
            end
            chm_pkg::S_PUT_WAIT:
            begin
                state_next = chm_pkg::S_PUT_WRITE;
            end
            chm_pkg::S_PUT_WRITE:
            begin
                ctl.put_write = 1'b1;
                ctl.set_ok    = 1'b1;
                state_next    = chm_pkg::S_DONE;
            end
            chm_pkg::S_DONE:
            begin
                ctl.emit   = 1'b1;
                state_next = chm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/chm_dp.sv
// datapath for the chained hash map: bucket heads, node pool, free stack
// depends on chm_pkg and chm_ram
`default_nettype none
module chm_dp #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int NODES   = chm_pkg::NODES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chm_pkg::in_word_t in_word,
    input  wire chm_pkg::ctl_t     ctl,
    output chm_pkg::dp_stat_t      stat,
    output chm_pkg::out_word_t     out_word,
    output logic                   out_strobe
);
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int CW = NW + 1;
    localparam int KW = chm_pkg::KEY_W;
    localparam int VW = chm_pkg::VAL_W;
    // link = valid bit plus node index
    localparam int LW = NW + 1;

    chm_pkg::in_word_t in_reg;
    logic [CW-1:0]     free_top_reg;
    logic [CW-1:0]     steps_reg;
    logic [NW-1:0]     init_cnt_reg;
    logic [LW-1:0]     cur_reg;
    logic [NW-1:0]     prev_reg;
    logic              at_head_reg;
    logic [BUCKETS-1:0] head_valid_reg;
    logic [1:0]        status_reg;
    logic [VW-1:0]     found_reg;
    logic              strobe_reg;

    logic [BW-1:0] bucket;
    logic [LW-1:0] head_rdata, link_rdata, head_eff, head_wdata;
    logic [KW-1:0] key_rdata;
    logic [VW-1:0] val_rdata;
    logic [NW-1:0] free_rdata, free_waddr, free_wdata, link_waddr;
    logic [LW-1:0] link_wdata;
    logic          free_we, head_we, link_we, node_we;
    logic          head_valid_rd_reg;

    assign bucket = in_reg.key[BW-1:0];

    // head ram: written on put and on erase of a head node
    assign head_we    = ctl.put_write || (ctl.erase_write && at_head_reg);
    assign head_wdata = ctl.put_write ? {1'b1, free_rdata} : link_rdata;

    chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(head_we), .waddr(bucket), .wdata(head_wdata),
        .re(ctl.rd_head), .raddr(bucket), .rdata(head_rdata)
    );

    // a bucket never written reads as empty
    assign head_eff = head_valid_rd_reg ? head_rdata : '0;

    assign node_we    = ctl.put_write;
    assign link_we    = ctl.put_write || (ctl.erase_write && !at_head_reg);
    assign link_waddr = ctl.put_write ? free_rdata : prev_reg;
    assign link_wdata = ctl.put_write ? head_eff : link_rdata;

    chm_ram #(.WIDTH(KW), .DEPTH(NODES)) u_keys (
        .clk(clk), .we(node_we), .waddr(free_rdata), .wdata(in_reg.key),
        .re(ctl.rd_node), .raddr(cur_reg[NW-1:0]), .rdata(key_rdata)
    );
    chm_ram #(.WIDTH(VW), .DEPTH(NODES)) u_vals (
        .clk(clk), .we(node_we), .waddr(free_rdata), .wdata(in_reg.value),
        .re(ctl.rd_node), .raddr(cur_reg[NW-1:0]), .rdata(val_rdata)
    );
    chm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(ctl.rd_node), .raddr(cur_reg[NW-1:0]), .rdata(link_rdata)
    );

    assign free_we    = ctl.init_step || (ctl.erase_write && free_top_reg < CW'(NODES));
    assign free_waddr = ctl.init_step ? init_cnt_reg : free_top_reg[NW-1:0];
    assign free_wdata = ctl.init_step ? init_cnt_reg : cur_reg[NW-1:0];

    logic [CW-1:0] top_m1;
    assign top_m1 = free_top_reg - CW'(1);

    chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .re(ctl.rd_free), .raddr(top_m1[NW-1:0]), .rdata(free_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg      <= CW'(NODES);
            init_cnt_reg      <= '0;
            head_valid_reg    <= '0;
            strobe_reg        <= 1'b0;
            head_valid_rd_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
            if (ctl.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + NW'(1);
            end
            if (ctl.rd_head)
            begin
                head_valid_rd_reg <= head_valid_reg[bucket];
            end
            if (ctl.put_write)
            begin
                head_valid_reg[bucket] <= 1'b1;
                free_top_reg           <= top_m1;
            end
            if (free_we && ctl.erase_write)
            begin
                free_top_reg <= free_top_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            in_reg <= in_word;
        end
        if (ctl.take_head)
        begin
            cur_reg     <= head_eff;
            steps_reg   <= '0;
            at_head_reg <= 1'b1;
        end
        if (ctl.advance)
        begin
            prev_reg    <= cur_reg[NW-1:0];
            cur_reg     <= link_rdata;
            steps_reg   <= steps_reg + CW'(1);
            at_head_reg <= 1'b0;
        end
        if (ctl.set_found)
        begin
            status_reg <= chm_pkg::ST_OK;
            found_reg  <= val_rdata;
        end
        if (ctl.set_ok)
        begin
            status_reg <= chm_pkg::ST_OK;
            found_reg  <= '0;
        end
        if (ctl.set_miss)
        begin
            status_reg <= chm_pkg::ST_NOTFOUND;
            found_reg  <= '0;
        end
        if (ctl.set_full)
        begin
            status_reg <= chm_pkg::ST_FULL;
            found_reg  <= '0;
        end
    end

    assign stat.init_last  = (init_cnt_reg == NW'(NODES - 1));
    assign stat.cur_ok     = cur_reg[LW-1] && (steps_reg < CW'(NODES));
    assign stat.key_match  = (key_rdata == in_reg.key);
    assign stat.pool_empty = (free_top_reg == '0);
    assign stat.op         = in_reg.op;

    assign out_word.status      = status_reg;
    assign out_word.found_value = found_reg;
    assign out_strobe           = strobe_reg;
endmodule
`default_nettype wire

### hw/rtl/chained_hash_map.sv
// top level of the chained hash map: controller, datapath and assertions
// depends on chm_pkg, chm_ctrl, chm_dp
`default_nettype none
// a hash map from 31-bit keys to 32-bit values, bucket = key mod BUCKETS,
// entries chained through a pool of NODES nodes. after reset the block fills
// its free stack with busy high. a word is taken when start is high and busy
// low; exactly one result word follows, shown for one cycle with done high, and
// it cannot be held off. a put reads the bucket head and the free stack, then
// writes the node and the head. a get or erase reads the bucket head, then one
// node after another; a walk that matches stops at the matching node. the walk
// is bound to NODES steps, with one read per node through the node memories. an unused op or
// a put to a full pool answers from the head state without a memory access.
// busy stays high until the cycle in which done is shown.
module chained_hash_map #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int NODES   = chm_pkg::NODES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire chm_pkg::in_word_t  in_word,
    output logic                    busy,
    output logic                    done,
    output chm_pkg::out_word_t      out_word
);
    chm_pkg::ctl_t     ctl;
    chm_pkg::dp_stat_t stat;

    // sequencing of memory reads and writes for each operation
    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .ctl(ctl), .busy(busy)
    );

    // bucket heads, node pool and free stack
    chm_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .ctl(ctl), .stat(stat),
        .out_word(out_word), .out_strobe(done)
    );

`ifndef SYNTHESIS
    // an accepted word always gets busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    // a result word is shown only while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");
    // a write to the pool never happens with the pool empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.put_write |-> !stat.pool_empty)
        else $error("pop from empty free stack");
`endif
endmodule
`default_nettype wire

### test/chained_hash_map_test.sv
// testbench for the chained hash map: directed and random get/put/erase words
// checked against a behavioral hash map with its own node pool and free stack
// depends on chm_pkg and chained_hash_map
`timescale 1ns / 100ps
`default_nettype none
module chained_hash_map_test;

    localparam int NBUCKET = chm_pkg::BUCKETS_DEF;
    localparam int NPOOL = chm_pkg::NODES_DEF;
    localparam int KW = chm_pkg::KEY_W;
    localparam int VW = chm_pkg::VAL_W;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    chm_pkg::in_word_t in_word;
    logic busy;
    logic done;
    chm_pkg::out_word_t out_word;

    chained_hash_map uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .in_word(in_word),
        .busy(busy),
        .done(done),
        .out_word(out_word)
    );

    // behavioral copy of the map state
    logic [KW-1:0] pool_key[NPOOL];
    logic [VW-1:0] pool_val[NPOOL];
    logic [8:0] pool_link[NPOOL];   // valid bit plus next index
    logic [8:0] head_of[NBUCKET];
    logic [7:0] free_list[NPOOL];
    int free_cnt;
    int live_cnt;

    chm_pkg::in_word_t pending_words[$];
    chm_pkg::out_word_t expected_words[$];
    logic [KW-1:0] live_keys[$];  // keys of the directed puts and the pool fill, to aim gets and erases
    int errors;
    int words_sent;
    int results_seen;
    int idle_pct;
    bit hold_off;
    int quiet_cycles;

    task automatic map_reset();
        for (int i = 0; i < NBUCKET; i++)
        begin
            head_of[i] = '0;
        end
        for (int i = 0; i < NPOOL; i++)
        begin
            free_list[i] = i[7:0];
            pool_key[i] = '0;
            pool_val[i] = '0;
            pool_link[i] = '0;
        end
        free_cnt = NPOOL;
        live_cnt = 0;
    endtask

    // apply one word to the map copy and return the answer it gives
    function automatic chm_pkg::out_word_t map_apply(chm_pkg::in_word_t w);
        chm_pkg::out_word_t r;
        logic [8:0] cur;
        logic [7:0] n;
        logic [7:0] prev;
        bit at_head;
        int b;
        int steps;
        r.status = chm_pkg::ST_NOTFOUND;
        r.found_value = '0;
        b = int'(w.key) % NBUCKET;
        prev = '0;
        at_head = 1'b1;
        steps = 0;
        case (chm_pkg::op_t'(w.op))
            chm_pkg::OP_GET:
            begin
                cur = head_of[b];
                while (cur[8] && steps < NPOOL)
                begin
                    n = cur[7:0];
                    if (pool_key[n] == w.key)
                    begin
                        r.status = chm_pkg::ST_OK;
                        r.found_value = pool_val[n];
                        break;
                    end
                    cur = pool_link[n];
                    steps++;
                end
            end
            chm_pkg::OP_PUT:
            begin
                if (free_cnt == 0)
                begin
                    r.status = chm_pkg::ST_FULL;
                end
                else
                begin
                    free_cnt--;
                    n = free_list[free_cnt];
                    pool_key[n] = w.key;
                    pool_val[n] = w.value;
                    pool_link[n] = head_of[b];
                    head_of[b] = {1'b1, n};
                    live_cnt++;
                    r.status = chm_pkg::ST_OK;
                end
            end
            chm_pkg::OP_ERASE:
            begin
                cur = head_of[b];
                while (cur[8] && steps < NPOOL)
                begin
                    n = cur[7:0];
                    if (pool_key[n] == w.key)
                    begin
                        if (at_head)
                            head_of[b] = pool_link[n];
                        else
                            pool_link[prev] = pool_link[n];
                        if (free_cnt < NPOOL)
                        begin
                            free_list[free_cnt] = n;
                            free_cnt++;
                        end
                        if (live_cnt > 0)
                            live_cnt--;
                        r.status = chm_pkg::ST_OK;
                        break;
                    end
                    prev = n;
                    at_head = 1'b0;
                    cur = pool_link[n];
                    steps++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic chm_pkg::in_word_t make_word(chm_pkg::op_t o, logic [KW-1:0] k,
                                                    logic [VW-1:0] v);
        chm_pkg::in_word_t w;
        w.op = o;
        w.key = k;
        w.value = v;
        return w;
    endfunction

    // key picker: often reuses a live key, else often a few buckets so chains grow long
    function automatic logic [KW-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45 && live_keys.size() > 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if (sel < 80)
            return KW'($urandom_range(0, 7) * NBUCKET + $urandom_range(0, 3));
        else
            return KW'($urandom());
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: start changes on the falling edge, accept seen at the rising edge
    chm_pkg::in_word_t cur_word;
    bit have_word;
    logic busy_at_edge;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            in_word <= '0;
            have_word = 1'b0;
        end
        else
        begin
            if (start && !busy_at_edge)
                have_word = 1'b0;   // word taken at the last rising edge
            if (!have_word && pending_words.size() > 0 && !hold_off
                && ($urandom_range(0, 99) >= idle_pct))
            begin
                cur_word = pending_words.pop_front();
                have_word = 1'b1;
            end
            start <= have_word;
            in_word <= have_word ? cur_word
                : make_word(chm_pkg::op_t'($urandom_range(0, 3)), KW'($urandom()), $urandom());
        end
    end

    // monitor: accept predictions at the rising edge, check result words
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (start && !busy)
            begin
                expected_words.push_back(map_apply(in_word));
                words_sent = words_sent + 1;
            end
            if (done)
            begin
                results_seen = results_seen + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, out_word);
                    errors = errors + 1;
                end
                else
                begin
                    chm_pkg::out_word_t exp_w;
                    exp_w = expected_words.pop_front();
                    if (out_word.status !== exp_w.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                            exp_w.status, out_word.status);
                        errors = errors + 1;
                    end
                    if (out_word.found_value !== exp_w.found_value)
                    begin
                        $display("%0t: found_value expected %h actual %h", $time,
                            exp_w.found_value, out_word.found_value);
                        errors = errors + 1;
                    end
                end
            end
            if (quiet_cycles > WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no progress", $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // the pending and expected queues drain in the driver/monitor; wait helpers
    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_words.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KW-1:0] k;
        int n_random;
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        idle_pct = 31;
        hold_off = 1'b0;
        busy_at_edge = 1'b1;
        map_reset();
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty map, extremes, unused op, duplicates, chain middle erase
        pending_words.push_back(make_word(chm_pkg::OP_GET, '0, '0));
        pending_words.push_back(make_word(chm_pkg::OP_ERASE, '1, '1));
        pending_words.push_back(make_word(chm_pkg::OP_NONE, '1, '1));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, '1, '1));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, '0, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, '1, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, '0, '1));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, 31'd5, 32'h1111_1111));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, 31'd5, 32'h2222_2222));
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd5, '0));
        pending_words.push_back(make_word(chm_pkg::OP_ERASE, 31'd5, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd5, '0));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, 31'd69, 32'h3333_3333));
        pending_words.push_back(make_word(chm_pkg::OP_PUT, 31'd133, 32'h4444_4444));
        pending_words.push_back(make_word(chm_pkg::OP_ERASE, 31'd69, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd5, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd133, '0));
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd197, '0));
        pending_words.push_back(make_word(chm_pkg::OP_ERASE, '1, '0));
        pending_words.push_back(make_word(chm_pkg::OP_ERASE, '0, '0));
        live_keys.push_back(31'd5);
        live_keys.push_back(31'd133);

        // fill the pool to full and past it, still with idling
        for (int i = 0; i < NPOOL + 3; i++)
        begin
            k = KW'(i * 3);
            live_keys.push_back(k);
            pending_words.push_back(make_word(chm_pkg::OP_PUT, k, $urandom()));
        end
        pending_words.push_back(make_word(chm_pkg::OP_GET, 31'd9, '0));

        // pause until every answer is in
        wait_drained();
        hold_off = 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk);
        hold_off = 1'b0;

        // random: erase-heavy first to drain the pool, then a mixed phase
        n_random = 1250;
        for (int i = 0; i < n_random; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            k = pick_key();
            if (i < 300)
                pending_words.push_back(make_word(r < 70 ? chm_pkg::OP_ERASE : chm_pkg::OP_GET,
                    k, $urandom()));
            else if (r < 40)
            begin
                pending_words.push_back(make_word(chm_pkg::OP_PUT, k, $urandom()));
                if (live_keys.size() < 64)
                    live_keys.push_back(k);
            end
            else if (r < 70)
                pending_words.push_back(make_word(chm_pkg::OP_GET, k, $urandom()));
            else if (r < 96)
                pending_words.push_back(make_word(chm_pkg::OP_ERASE, k, $urandom()));
            else
                pending_words.push_back(make_word(chm_pkg::OP_NONE, k, $urandom()));
            // a long stretch with no idling in the middle
            if (i == 600)
            begin
                wait_drained();
                idle_pct = 0;
            end
            if (i == 900)
            begin
                wait_drained();
                idle_pct = 31;
            end
        end
        wait_drained();
        repeat (3 * NPOOL + 20) @(posedge clk);

        $display("ran %0d words (get/put/erase/unused op, pool full and drained), %0d results",
            words_sent, results_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
